// File: rtl/tlshr_pkg.sv
`timescale 1ns / 1ps

package tlshr_pkg;

  localparam logic [7:0]  TYPE_HANDSHAKE  = 8'd22;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
  localparam logic [2:0]  HDR_BYTES       = 3'd4;
  localparam logic [16:0] SEEN_MAX        = 17'h1FFFF;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_ONGOING    = 3'd0,
    ST_SKIPPED    = 3'd1,
    ST_CH_READY   = 3'd2,
    ST_NOT_TARGET = 3'd3,
    ST_BROKEN     = 3'd4,
    ST_STOPPED    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  content_type;
    logic [15:0] declared_len;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        record_end;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] msg_byte;
    logic       msg_byte_valid;
    logic [7:0] msg_type;
    logic       msg_last;
  } result_t;

endpackage

// File: rtl/tlshr_in_stage.sv
`timescale 1ns / 1ps

module tlshr_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tlshr_pkg::item_t in_item,
  input  logic           downstream_ready,
  output logic           step,
  output tlshr_pkg::item_t item
);
  import tlshr_pkg::*;

  logic  valid_r;
  item_t item_r;

  // advance whenever the result register can take the computed result
  assign step     = valid_r && downstream_ready;
  assign in_ready = !valid_r || downstream_ready;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/tlshr_engine.sv
`timescale 1ns / 1ps

module tlshr_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  tlshr_pkg::item_t   item,
  output tlshr_pkg::result_t result
);
  import tlshr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [23:0] exp_r, exp_nxt;
  logic [23:0] body_r, body_nxt;
  logic [16:0] rec_r, rec_nxt;

  logic [17:0] seen_sum;
  logic [16:0] seen;
  logic        is_hs;
  logic        len_bad;
  logic        assembling;
  logic        done;
  logic [2:0]  hdr_cnt_inc;
  logic [23:0] body_inc;

  assign seen_sum    = {1'b0, rec_r} + {17'd0, item.has_byte};
  assign seen        = seen_sum[17] ? SEEN_MAX : seen_sum[16:0];
  assign is_hs       = (item.content_type == TYPE_HANDSHAKE);
  assign len_bad     = (seen != {1'b0, item.declared_len});
  assign assembling  = (phase_r == PH_BODY) || (hdr_cnt_r != 3'd0);
  assign hdr_cnt_inc = hdr_cnt_r + 3'd1;
  assign body_inc    = body_r + 24'd1;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    kind_nxt    = kind_r;
    exp_nxt     = exp_r;
    body_nxt    = body_r;
    rec_nxt     = rec_r;
    done        = 1'b0;
    if (phase_r != PH_STOP) begin
      rec_nxt = item.record_end ? 17'd0 : seen;
      if (item.record_end && (len_bad || !is_hs)) begin
        phase_nxt = PH_STOP;
      end else if (is_hs && item.has_byte) begin
        if (phase_r == PH_HEADER) begin
          if (hdr_cnt_r == 3'd0) begin
            kind_nxt = item.data_byte;
            exp_nxt  = 24'd0;
          end else begin
            exp_nxt = {exp_r[15:0], item.data_byte};
          end
          hdr_cnt_nxt = hdr_cnt_inc;
          if (hdr_cnt_inc >= HDR_BYTES) begin
            hdr_cnt_nxt = HDR_BYTES;
            phase_nxt   = PH_BODY;
            body_nxt    = 24'd0;
            done        = (exp_nxt == 24'd0);
          end
        end else begin
          body_nxt = body_inc;
          done     = (body_inc >= exp_r);
        end
        if (done) begin
          if (kind_nxt == HS_CLIENT_HELLO) begin
            phase_nxt = PH_STOP;
          end else begin
            phase_nxt   = PH_HEADER;
            hdr_cnt_nxt = 3'd0;
            kind_nxt    = 8'd0;
            exp_nxt     = 24'd0;
            body_nxt    = 24'd0;
          end
        end
      end
    end
  end

  // result of this item
  always_comb begin
    result = '{status: ST_ONGOING, msg_byte: 8'd0, msg_byte_valid: 1'b0,
               msg_type: 8'd0, msg_last: 1'b0};
    if (phase_r == PH_STOP) begin
      result.status = ST_STOPPED;
    end else if (item.record_end && len_bad) begin
      result.status = ST_BROKEN;
    end else if (item.record_end && !is_hs) begin
      result.status = assembling ? ST_BROKEN : ST_NOT_TARGET;
    end else if (is_hs && item.has_byte) begin
      result.msg_byte       = item.data_byte;
      result.msg_byte_valid = 1'b1;
      result.msg_type       = (phase_r == PH_HEADER && hdr_cnt_r == 3'd0) ?
                              item.data_byte : kind_r;
      if (done) begin
        result.msg_last = 1'b1;
        result.status   = (result.msg_type == HS_CLIENT_HELLO) ? ST_CH_READY : ST_SKIPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= 3'd0;
      kind_r    <= 8'd0;
      exp_r     <= 24'd0;
      body_r    <= 24'd0;
      rec_r     <= 17'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      kind_r    <= kind_nxt;
      exp_r     <= exp_nxt;
      body_r    <= body_nxt;
      rec_r     <= rec_nxt;
    end
  end

endmodule

// File: rtl/tls_handshake_reassembler_core.sv
`timescale 1ns / 1ps
// Handshake message reassembler for a TLS record byte stream.
// Input channel (in_valid/in_ready): one record body byte per item, tagged
// with the record's content type, declared length and an end-of-record mark;
// an item with in_has_byte low carries no byte.
// Result channel (out_valid/out_ready): exactly one result item per input
// item, in order: a status code plus the handshake byte passed on, its
// message type and a last mark on the final byte of a complete message.
// Each item passes the input register, then the result register.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single state update between the two registers.
// Reset (rst_n low, synchronous) empties both registers and returns the
// assembly state to waiting for a header with all counters at zero.
// When the receiver stalls, the result register holds its item, the input
// register holds the next one, and in_ready drops only when both are full.
// Once the flow stops (ClientHello complete, non-handshake record, length
// mismatch) every later item answers status 5 until reset.

module tls_handshake_reassembler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_content_type,
  input  logic [15:0] in_declared_len,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_record_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_msg_byte,
  output logic        out_msg_byte_valid,
  output logic [7:0]  out_msg_type,
  output logic        out_msg_last
);
  import tlshr_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    step;
  logic    res_ready;
  result_t result;
  logic    out_valid_r;
  result_t out_r;

  assign in_item = '{content_type: in_content_type, declared_len: in_declared_len,
                     data_byte: in_data_byte, has_byte: in_has_byte,
                     record_end: in_record_end};

  // result register is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  tlshr_in_stage u_in_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .downstream_ready (res_ready),
    .step             (step),
    .item             (item)
  );

  tlshr_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .result (result)
  );

  // hold the result while the receiver stalls, load a new one on each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_msg_byte       = out_r.msg_byte;
  assign out_msg_byte_valid = out_r.msg_byte_valid;
  assign out_msg_type       = out_r.msg_type;
  assign out_msg_last       = out_r.msg_last;

endmodule

// File: rtl/tlshr_chk.sv
`timescale 1ns / 1ps

module tlshr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [7:0] out_msg_byte,
  input logic       out_msg_byte_valid,
  input logic [7:0] out_msg_type,
  input logic       out_msg_last
);
  import tlshr_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_msg_byte) && $stable(out_msg_last))
    else $error("result item changed while stalled");

  // no byte passed on means all byte fields are zero and no last mark
  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_msg_byte_valid |->
      out_msg_byte == 8'd0 && out_msg_type == 8'd0 && !out_msg_last)
    else $error("byte fields set without a message byte");

  // a last mark goes with a finished message status, and only with it
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_msg_last == (out_status == ST_SKIPPED ||
      out_status == ST_CH_READY)))
    else $error("last mark and completion status disagree");

  // a taken stop result is directly followed by an idle output or a stopped result
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_status == ST_CH_READY ||
      out_status == ST_NOT_TARGET || out_status == ST_BROKEN ||
      out_status == ST_STOPPED)
    |=> !out_valid || out_status == ST_STOPPED)
    else $error("result after a stop is not stopped");

endmodule

bind tls_handshake_reassembler_core tlshr_chk u_tlshr_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_msg_byte       (out_msg_byte),
  .out_msg_byte_valid (out_msg_byte_valid),
  .out_msg_type       (out_msg_type),
  .out_msg_last       (out_msg_last)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the TLS handshake reassembler. An initial block
// builds the whole item stream up front (directed records, then random
// handshake traffic cut into records, then one flow-stopping sequence and items after it).
// A clocked driver feeds it to the block, and a clocked monitor checks
// every result item against the predicted one.
module tb_top;
  import tlshr_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles without any accepted item
  localparam int TAIL_CYCLES = 8;     // results trail acceptance through two registers; allow slack

  typedef struct packed {
    item_t it;
    logic  drain;  // hold this item back until every result is in
  } feed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_content_type = '0;
  logic [15:0] in_declared_len = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_has_byte = 1'b0;
  logic        in_record_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_msg_byte;
  logic        out_msg_byte_valid;
  logic [7:0]  out_msg_type;
  logic        out_msg_last;

  tls_handshake_reassembler_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_content_type   (in_content_type),
    .in_declared_len   (in_declared_len),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_record_end     (in_record_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_msg_byte      (out_msg_byte),
    .out_msg_byte_valid(out_msg_byte_valid),
    .out_msg_type      (out_msg_type),
    .out_msg_last      (out_msg_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stream under construction and the items waiting to be driven.
  logic [7:0] hs_stream[$];
  feed_t      feed_q[$];
  result_t    expected_q[$];
  logic       drain_next = 1'b0;

  int n_total = 1;
  int n_sent = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_status[6];
  string stop_name = "";

  // Shadow of the assembly state, advanced once per accepted item.
  phase_t      asm_phase = PH_HEADER;
  logic [2:0]  hdr_cnt = '0;
  logic [7:0]  cur_type = '0;
  logic [23:0] body_len = '0;
  logic [23:0] body_cnt = '0;
  logic [16:0] rec_cnt = '0;

  // Work out the result item for one input item and advance the shadow state.
  function automatic result_t predict_reassembly(item_t it);
    result_t     r;
    logic [17:0] cnt;
    logic        complete;
    r = '0;
    r.status = ST_ONGOING;
    complete = 1'b0;
    if (asm_phase == PH_STOP) begin
      r.status = ST_STOPPED;
      return r;
    end
    cnt = {1'b0, rec_cnt} + {17'd0, it.has_byte};
    if (cnt > {1'b0, SEEN_MAX}) cnt = {1'b0, SEEN_MAX};
    // Record checks come first and only at the record's last item:
    // length before content type, and a failed check drops that item's byte.
    if (it.record_end) begin
      rec_cnt = '0;
      if (cnt != {2'b00, it.declared_len}) begin
        asm_phase = PH_STOP;
        r.status = ST_BROKEN;
        return r;
      end
      if (it.content_type != TYPE_HANDSHAKE) begin
        r.status = (asm_phase == PH_BODY || hdr_cnt != 0) ? ST_BROKEN : ST_NOT_TARGET;
        asm_phase = PH_STOP;
        return r;
      end
    end else begin
      rec_cnt = cnt[16:0];
    end
    if (it.content_type != TYPE_HANDSHAKE || !it.has_byte) return r;
    if (asm_phase == PH_HEADER) begin
      if (hdr_cnt == 0) begin
        cur_type = it.data_byte;
        body_len = '0;
      end else begin
        body_len = {body_len[15:0], it.data_byte};
      end
      hdr_cnt++;
      if (hdr_cnt == HDR_BYTES) begin
        asm_phase = PH_BODY;
        body_cnt = '0;
        complete = (body_len == 0);  // empty body ends on the last header byte
      end
    end else begin
      body_cnt++;
      complete = (body_cnt >= body_len);
    end
    r.msg_byte = it.data_byte;
    r.msg_byte_valid = 1'b1;
    r.msg_type = cur_type;
    if (complete) begin
      r.msg_last = 1'b1;
      if (cur_type == HS_CLIENT_HELLO) begin
        asm_phase = PH_STOP;
        r.status = ST_CH_READY;
      end else begin
        r.status = ST_SKIPPED;
        asm_phase = PH_HEADER;
        hdr_cnt = '0;
        cur_type = '0;
        body_len = '0;
        body_cnt = '0;
      end
    end
    return r;
  endfunction

  function automatic item_t mk_item(logic [7:0] cty, logic [15:0] dlen, logic [7:0] b,
                                    logic has, logic is_end);
    item_t it;
    it.content_type = cty;
    it.declared_len = dlen;
    it.data_byte = b;
    it.has_byte = has;
    it.record_end = is_end;
    return it;
  endfunction

  task automatic add_feed(item_t it);
    feed_t f;
    f.it = it;
    f.drain = drain_next;
    drain_next = 1'b0;
    feed_q.push_back(f);
  endtask

  // Append one handshake message (header plus random body) to the stream.
  task automatic queue_message(logic [7:0] kind, logic [23:0] len);
    hs_stream.push_back(kind);
    hs_stream.push_back(len[23:16]);
    hs_stream.push_back(len[15:8]);
    hs_stream.push_back(len[7:0]);
    for (int i = 0; i < len; i++) hs_stream.push_back(8'($urandom_range(0, 255)));
  endtask

  // Cut the next handshake record off the stream. Sprinkle foreign-type
  // and byteless items inside it, sometimes close it with a byteless end
  // item, and now and then emit an empty record.
  task automatic cut_record(int max_bytes);
    item_t rec[$];
    item_t it;
    int    n;
    int    cnt;
    n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, max_bytes);
    if (n > hs_stream.size()) n = hs_stream.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        it = mk_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        // a byte under the handshake type would join the message; keep it foreign
        if (it.has_byte && it.content_type == TYPE_HANDSHAKE) it.content_type = 8'h17;
        rec.push_back(it);
      end
      rec.push_back(mk_item(TYPE_HANDSHAKE, '0, hs_stream.pop_front(), 1'b1, 1'b0));
    end
    if (rec.size() == 0 || $urandom_range(0, 3) == 0)
      rec.push_back(mk_item(TYPE_HANDSHAKE, '0, 8'($urandom_range(0, 255)), 1'b0, 1'b0));
    rec[rec.size() - 1].record_end = 1'b1;
    cnt = 0;
    foreach (rec[i]) cnt += rec[i].has_byte;
    // Only the closing item's length is checked; leave some mid-record ones as built.
    foreach (rec[i]) begin
      if (rec[i].record_end || $urandom_range(0, 7) != 0) rec[i].declared_len = 16'(cnt);
      add_feed(rec[i]);
    end
  endtask

  // Build the stimulus, release reset, then wait for the block to drain.
  initial begin
    int          k;
    logic [7:0]  fty;
    logic [15:0] bad_len;

    // Directed: empty record.
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd0, 8'h00, 1'b0, 1'b1));
    // Type 0 with a zero body length, complete on its fourth header byte.
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd4, 8'h00, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd4, 8'h00, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd4, 8'h00, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd4, 8'h00, 1'b1, 1'b1));
    // Foreign byte with extreme fields ahead of a type 255 header; the body
    // of that message then runs into the next record.
    add_feed(mk_item(8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd5, 8'hFF, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd5, 8'h00, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd5, 8'h00, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd5, 8'h02, 1'b1, 1'b1));
    // Body split by a byteless foreign item; the message completes before
    // the record does, and a byteless item closes the record.
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd2, 8'hFF, 1'b1, 1'b0));
    add_feed(mk_item(8'h00, 16'd0, 8'hAA, 1'b0, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd2, 8'h00, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd2, 8'h55, 1'b0, 1'b1));
    // Header split across two records.
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd2, 8'h02, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd2, 8'h00, 1'b1, 1'b1));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd3, 8'h00, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd3, 8'h01, 1'b1, 1'b0));
    add_feed(mk_item(TYPE_HANDSHAKE, 16'd3, 8'h5A, 1'b1, 1'b1));

    // Random traffic: non-ClientHello messages, mostly short, cut into
    // records whose boundaries ignore message boundaries. Keep long
    // messages away from the end so the item count stays near its target.
    drain_next = 1'b1;
    while (feed_q.size() < 1040) begin
      fty = 8'($urandom_range(0, 255));
      if (fty == HS_CLIENT_HELLO) fty = 8'd2;
      queue_message(fty, (feed_q.size() < 900 && $urandom_range(0, 9) == 0) ?
                         24'($urandom_range(20, 200)) : 24'($urandom_range(0, 12)));
      while (hs_stream.size() > $urandom_range(0, 8)) cut_record(16);
    end
    while (hs_stream.size() != 0) cut_record(16);

    // One flow-stopping sequence; the block stays stopped until reset.
    drain_next = 1'b1;
    fty = 8'($urandom_range(0, 255));
    if (fty == TYPE_HANDSHAKE) fty = 8'h15;
    case ($urandom_range(0, 3))
      0: begin
        stop_name = "a complete ClientHello";
        queue_message(HS_CLIENT_HELLO, 24'($urandom_range(0, 6)));
        while (hs_stream.size() != 0) cut_record(16);
      end
      1: begin
        stop_name = "a foreign record between messages";
        k = $urandom_range(0, 3);
        if (k == 0) add_feed(mk_item(fty, 16'd0, 8'h00, 1'b0, 1'b1));
        for (int i = 0; i < k; i++)
          add_feed(mk_item(fty, 16'(k), 8'($urandom_range(0, 255)), 1'b1, i == k - 1));
      end
      2: begin
        stop_name = "a foreign record inside a header";
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
          add_feed(mk_item(TYPE_HANDSHAKE, 16'(k), 8'($urandom_range(0, 255)), 1'b1,
                           i == k - 1));
        add_feed(mk_item(fty, 16'd1, 8'($urandom_range(0, 255)), 1'b1, 1'b1));
      end
      default: begin
        stop_name = "a record length mismatch";
        k = $urandom_range(0, 3);
        bad_len = 16'($urandom_range(0, 65535));
        if (bad_len == k) bad_len = 16'hFFFF;
        if (k == 0) add_feed(mk_item(TYPE_HANDSHAKE, bad_len, 8'h00, 1'b0, 1'b1));
        for (int i = 0; i < k; i++)
          add_feed(mk_item(TYPE_HANDSHAKE, bad_len, 8'($urandom_range(0, 255)), 1'b1,
                           i == k - 1));
      end
    endcase
    // Anything after the stop must come back as stopped.
    for (int i = 0; i < 6; i++)
      add_feed(mk_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1))));
    n_total = feed_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $write("Sent %0d items, checked %0d results: %0d skipped, %0d ClientHello ready, ",
           n_sent, n_results, n_status[ST_SKIPPED], n_status[ST_CH_READY]);
    $display("%0d not target, %0d broken, %0d stopped",
             n_status[ST_NOT_TARGET], n_status[ST_BROKEN], n_status[ST_STOPPED]);
    $display("Flow ended by %s; idling swept sender-heavy, receiver-heavy and none", stop_name);
    if (n_errors == 0) begin
      $display("tls_handshake_reassembler_core test passed");
    end else begin
      $display("tls_handshake_reassembler_core test failed");
    end
    $finish;
  end

  // Driver: predict on acceptance, then present the next item or idle.
  // Idling follows the run's thirds: sender 21 % / receiver 62 %, then
  // the other way round, then none.
  always @(posedge clk) begin
    feed_t f;
    logic  launch;
    int    stage;
    int    idle_pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        f = feed_q.pop_front();
        expected_q.push_back(predict_reassembly(f.it));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        stage = n_sent * 3 / n_total;
        idle_pct = (stage == 0) ? 21 : (stage == 1) ? 62 : 0;
        launch = 1'b0;
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
          launch = !feed_q[0].drain || expected_q.size() == 0;
        if (launch) begin
          in_content_type <= feed_q[0].it.content_type;
          in_declared_len <= feed_q[0].it.declared_len;
          in_data_byte    <= feed_q[0].it.data_byte;
          in_has_byte     <= feed_q[0].it.has_byte;
          in_record_end   <= feed_q[0].it.record_end;
        end
        in_valid <= launch;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    int      stage;
    int      idle_pct;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (out_status <= 3'd5) n_status[out_status]++;
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting (status %0d)", out_status);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            n_errors++;
          end
          if (out_msg_byte !== want.msg_byte) begin
            $error("msg_byte: expected %0h, got %0h", want.msg_byte, out_msg_byte);
            n_errors++;
          end
          if (out_msg_byte_valid !== want.msg_byte_valid) begin
            $error("msg_byte_valid: expected %0b, got %0b", want.msg_byte_valid,
                   out_msg_byte_valid);
            n_errors++;
          end
          if (out_msg_type !== want.msg_type) begin
            $error("msg_type: expected %0h, got %0h", want.msg_type, out_msg_type);
            n_errors++;
          end
          if (out_msg_last !== want.msg_last) begin
            $error("msg_last: expected %0b, got %0b", want.msg_last, out_msg_last);
            n_errors++;
          end
        end
      end
      stage = n_sent * 3 / n_total;
      idle_pct = (stage == 0) ? 62 : (stage == 1) ? 21 : 0;
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("tls_handshake_reassembler_core test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
